/* hdl/text_console_glyph_renderer_assert.svh */
// assertion macros for the text console glyph renderer
// used by text_console_glyph_renderer.sv, no other dependencies
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCGR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcgr same-cycle check failed");

// next-cycle implication, checked outside reset
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcgr next-cycle check failed");

`endif

/* hdl/tcgr_pkg.sv */
// shared types and constants of the text console glyph renderer
// no dependencies; used by tcgr_div and text_console_glyph_renderer
`default_nettype none

package tcgr_pkg;

   // default sizes
   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int DEF_MAX_HEIGHT  = 4096;
   localparam int DEF_GLYPH_ROWS  = 16;
   localparam int DEF_GLYPH_COUNT = 256;

   // field widths
   localparam int CSR_W   = 13;
   localparam int POS_W   = 21;
   localparam int CNT_W   = $clog2(POS_W + 1);
   localparam int COORD_W = 12;
   localparam int ADDR_W  = 12;
   localparam int BYTE_W  = 8;

   // register indexes
   localparam logic IDX_SCREEN_WIDTH  = 1'b0;
   localparam logic IDX_SCREEN_HEIGHT = 1'b1;

   // register reset values
   localparam logic [CSR_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [CSR_W-1:0] RST_SCREEN_HEIGHT = 13'd480;

   // action codes
   localparam logic ACT_PRINT    = 1'b0;
   localparam logic ACT_GLYPH_WR = 1'b1;

   // result kinds
   localparam logic KIND_ROW   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // character codes
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DRAW
   } tcgr_state_type;

   typedef enum logic [1:0] {
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_GLYPH
   } tcgr_op_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] quot;
      logic [CSR_W-1:0] rem;
   } tcgr_div_res_type;

endpackage

`default_nettype wire

/* hdl/tcgr_div.sv */
// restoring divider, one quotient bit per cycle: cursor position by screen width
// depends on tcgr_pkg
`default_nettype none

module tcgr_div (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [tcgr_pkg::POS_W-1:0]     dividend,
   input  wire  [tcgr_pkg::CSR_W-1:0]     divisor,
   output tcgr_pkg::tcgr_div_res_type     res
);

   logic [tcgr_pkg::POS_W-1:0] quo_ff;
   logic [tcgr_pkg::CSR_W-1:0] rem_ff;
   logic [tcgr_pkg::CNT_W-1:0] cnt_ff;
   logic                       done_ff;

   logic [tcgr_pkg::CSR_W:0]   trial;
   logic                       fits;
   logic [tcgr_pkg::CSR_W-1:0] rem_in;

   // one restoring step
   always_comb begin
      trial  = {rem_ff, quo_ff[tcgr_pkg::POS_W-1]};
      fits   = (trial >= {1'b0, divisor});
      rem_in = fits ? tcgr_pkg::CSR_W'(trial - {1'b0, divisor})
                    : trial[tcgr_pkg::CSR_W-1:0];
   end

   // quotient bits shift in behind the dividend
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[tcgr_pkg::POS_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == tcgr_pkg::CNT_W'(1)) && !start;
         if (start) begin
            cnt_ff <= tcgr_pkg::CNT_W'(tcgr_pkg::POS_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - tcgr_pkg::CNT_W'(1);
         end
      end
   end

   assign res.done = done_ff;
   assign res.quot = quo_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

/* hdl/text_console_glyph_renderer.sv */
// Text console glyph renderer: a character stream in, glyph rows and screen
// clears out.
//
// Channels: req_ carries one item (print a character, or write one byte of the
// glyph store); rsp_ carries result items; csr_ writes screen_width (index 0)
// or screen_height (index 1) and is always ready.
// Flow: a glyph store write gives no result. A drawn character is taken only
// when idle, and no new item is accepted until it is finished: first the
// screen-end check (the clear item, if any, is loaded there), then the
// one-bit-per-cycle divider that splits the cursor into text row and pixel
// column, then reads of one glyph row per cycle from the glyph memory, while
// the output register can take them. Newline and carriage return end after
// the divider. After reset and after a register write the input holds ready
// low while the screen-end limit is recomputed.
// Reset: cursor goes to zero, registers to 640 by 480; the glyph store holds
// garbage until written, so glyphs must be loaded before they are printed.
// Stalls: results sit in one output register; while it is full and rsp_ready
// is low the sequencer waits, and no result is dropped.
// depends on tcgr_pkg, tcgr_div and text_console_glyph_renderer_assert.svh
`default_nettype none

`include "text_console_glyph_renderer_assert.svh"

module text_console_glyph_renderer #(
   parameter int MAX_WIDTH   = tcgr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = tcgr_pkg::DEF_MAX_HEIGHT,
   parameter int GLYPH_ROWS  = tcgr_pkg::DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
   input  wire                               clock,
   input  wire                               reset,
   // input items
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_action,
   input  wire  [7:0]                        req_char_code,
   input  wire  [tcgr_pkg::ADDR_W-1:0]       req_glyph_addr,
   input  wire  [tcgr_pkg::BYTE_W-1:0]       req_glyph_data,
   // result items
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_kind,
   output logic [tcgr_pkg::COORD_W-1:0]      rsp_pixel_x,
   output logic [tcgr_pkg::COORD_W-1:0]      rsp_pixel_y,
   output logic [tcgr_pkg::BYTE_W-1:0]       rsp_row_bits,
   output logic                              rsp_last,
   // register writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire                               csr_index,
   input  wire  [tcgr_pkg::CSR_W-1:0]        csr_data
);

   localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(GLYPH_ROWS + 1);
   // reciprocal for height / GLYPH_ROWS, exact over 13-bit heights
   localparam int HS    = tcgr_pkg::CSR_W + $clog2(GLYPH_ROWS);
   localparam int HM    = (2 ** HS + GLYPH_ROWS - 1) / GLYPH_ROWS;
   localparam int HQ_W  = tcgr_pkg::CSR_W - 3;
   localparam int PW    = 2 * tcgr_pkg::CSR_W + 2;
   localparam int LIM_W = tcgr_pkg::CSR_W + HQ_W;
   localparam int PW_ = tcgr_pkg::POS_W;

   // ---------------------------------------------------------------- registers
   logic [tcgr_pkg::CSR_W-1:0] width_ff;
   logic [tcgr_pkg::CSR_W-1:0] height_ff;
   logic [tcgr_pkg::CSR_W-1:0] w_eff_ff;
   logic [HQ_W-1:0]            hq_ff;
   logic [LIM_W-1:0]           limit_ff;
   logic [1:0]                 settle_ff;

   logic [tcgr_pkg::CSR_W:0]   w_clamp;
   logic [tcgr_pkg::CSR_W:0]   h_clamp;
   logic [PW-1:0]              h_prod;

   tcgr_pkg::tcgr_state_type   state_ff, state_in;
   tcgr_pkg::tcgr_op_type      op_ff, op_in;
   logic [7:0]                 char_ff;
   logic [PW_-1:0]             cursor_ff, cursor_in;
   logic [PW_-1:0]             pos_cur_ff, pos_cur;
   logic [AW-1:0]              base_ff, base_in;
   logic [tcgr_pkg::COORD_W-1:0] x_ff;
   logic [tcgr_pkg::COORD_W-1:0] y0_ff;
   logic [RW-1:0]              iss_cnt_ff;
   logic [RW-1:0]              emi_cnt_ff;
   logic                       rd_pend_ff;
   logic [tcgr_pkg::BYTE_W-1:0] rd_data_ff;
   logic [tcgr_pkg::BYTE_W-1:0] glyph_mem [DEPTH];

   logic                       rsp_valid_ff;
   logic                       rsp_kind_ff;
   logic [tcgr_pkg::COORD_W-1:0] rsp_x_ff;
   logic [tcgr_pkg::COORD_W-1:0] rsp_y_ff;
   logic [tcgr_pkg::BYTE_W-1:0] rsp_bits_ff;
   logic                       rsp_last_ff;

   // ---------------------------------------------------------------- control
   logic                       req_acc;
   logic                       csr_acc;
   logic                       mem_we;
   logic [AW-1:0]              mem_wr_addr;
   logic                       out_free;
   logic                       at_end;
   logic                       proceed;
   logic [PW_-1:0]             dividend;
   logic [7:0]                 glyph_sel;
   logic                       div_start;
   tcgr_pkg::tcgr_div_res_type div_res;

   logic                       rsp_load;
   logic                       rsp_kind_in;
   logic [tcgr_pkg::COORD_W-1:0] rsp_x_in;
   logic [tcgr_pkg::COORD_W-1:0] rsp_y_in;
   logic [tcgr_pkg::BYTE_W-1:0] rsp_bits_in;
   logic                       rsp_last_in;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic                       draw_last;
   logic                       rd_ahead_ok;
   logic                       last_row_done;

   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign req_ready = (state_ff == tcgr_pkg::ST_IDLE) && (settle_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tcgr_pkg::RST_SCREEN_WIDTH;
         height_ff <= tcgr_pkg::RST_SCREEN_HEIGHT;
         settle_ff <= 2'd3;
      end else begin
         if (csr_acc) begin
            settle_ff <= 2'd3;
            case (csr_index)
               tcgr_pkg::IDX_SCREEN_WIDTH:  width_ff  <= csr_data;
               tcgr_pkg::IDX_SCREEN_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // clamped size and screen-end limit, two multiplier stages
   always_comb begin
      w_clamp = {1'b0, width_ff};
      if (w_clamp < (tcgr_pkg::CSR_W + 1)'(8)) w_clamp = (tcgr_pkg::CSR_W + 1)'(8);
      if (w_clamp > (tcgr_pkg::CSR_W + 1)'(MAX_WIDTH))
         w_clamp = (tcgr_pkg::CSR_W + 1)'(MAX_WIDTH);
      h_clamp = {1'b0, height_ff};
      if (h_clamp < (tcgr_pkg::CSR_W + 1)'(GLYPH_ROWS))
         h_clamp = (tcgr_pkg::CSR_W + 1)'(GLYPH_ROWS);
      if (h_clamp > (tcgr_pkg::CSR_W + 1)'(MAX_HEIGHT))
         h_clamp = (tcgr_pkg::CSR_W + 1)'(MAX_HEIGHT);
      h_prod = PW'(h_clamp) * PW'(HM);
   end

   always_ff @(posedge clock) begin
      w_eff_ff <= w_clamp[tcgr_pkg::CSR_W-1:0];
      hq_ff    <= h_prod[HS +: HQ_W];
      limit_ff <= LIM_W'(w_eff_ff) * LIM_W'(hq_ff);
   end

   // glyph store: write port from the input, read port for drawing
   assign mem_we      = req_acc && (req_action == tcgr_pkg::ACT_GLYPH_WR)
                        && ({2'b0, req_glyph_addr} < (tcgr_pkg::ADDR_W + 2)'(DEPTH));
   assign mem_wr_addr = AW'({2'b0, req_glyph_addr});

   // reads and writes never overlap: writes only happen while no character is in work
   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[mem_wr_addr] <= req_glyph_data;
      end
      if (rd_en) begin
         rd_data_ff <= glyph_mem[rd_addr];
      end
   end

   // screen-end check and operation decode
   always_comb begin
      at_end  = ({{(LIM_W - PW_){1'b0}}, cursor_ff} >= limit_ff);
      pos_cur = at_end ? '0 : cursor_ff;
      case (char_ff)
         tcgr_pkg::CH_NEWLINE:   op_in = tcgr_pkg::OP_NEWLINE;
         tcgr_pkg::CH_RETURN:    op_in = tcgr_pkg::OP_RETURN;
         tcgr_pkg::CH_BACKSPACE: op_in = (pos_cur >= PW_'(8)) ? tcgr_pkg::OP_BACKSPACE
                                                              : tcgr_pkg::OP_GLYPH;
         default:                op_in = tcgr_pkg::OP_GLYPH;
      endcase
      dividend = (op_in == tcgr_pkg::OP_BACKSPACE) ? PW_'(pos_cur - PW_'(8)) : pos_cur;
      if (op_in == tcgr_pkg::OP_BACKSPACE) begin
         glyph_sel = tcgr_pkg::CH_SPACE;
      end else if ({1'b0, char_ff} >= 9'(GLYPH_COUNT)) begin
         glyph_sel = tcgr_pkg::CH_SPACE;
      end else begin
         glyph_sel = char_ff;
      end
      base_in = AW'(AW'(glyph_sel) * AW'(GLYPH_ROWS));
      proceed = !at_end || out_free;
   end

   // cursor after the character
   always_comb begin
      case (op_ff)
         tcgr_pkg::OP_NEWLINE:
            cursor_in = PW_'(pos_cur_ff - PW_'(div_res.rem) + PW_'(w_eff_ff));
         tcgr_pkg::OP_RETURN:
            cursor_in = PW_'(pos_cur_ff - PW_'(div_res.rem));
         tcgr_pkg::OP_BACKSPACE:
            cursor_in = PW_'(pos_cur_ff - PW_'(8));
         default:
            cursor_in = PW_'(pos_cur_ff + PW_'(8));
      endcase
   end

   tcgr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (w_eff_ff),
      .res      (div_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcgr_pkg::ST_IDLE: begin
            if (req_acc && (req_action == tcgr_pkg::ACT_PRINT)) state_in = tcgr_pkg::ST_CHECK;
         end
         tcgr_pkg::ST_CHECK: begin
            if (proceed) state_in = tcgr_pkg::ST_DIV;
         end
         tcgr_pkg::ST_DIV: begin
            if (div_res.done) begin
               if (op_ff inside {tcgr_pkg::OP_NEWLINE, tcgr_pkg::OP_RETURN}) begin
                  state_in = tcgr_pkg::ST_IDLE;
               end else begin
                  state_in = tcgr_pkg::ST_DRAW;
               end
            end
         end
         tcgr_pkg::ST_DRAW: begin
            if (rsp_load && draw_last) state_in = tcgr_pkg::ST_IDLE;
         end
         default: state_in = tcgr_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      rsp_kind_in = tcgr_pkg::KIND_ROW;
      rsp_x_in    = '0;
      rsp_y_in    = '0;
      rsp_bits_in = '0;
      rsp_last_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = AW'(base_ff + AW'(iss_cnt_ff));
      draw_last   = (emi_cnt_ff == RW'(GLYPH_ROWS - 1));
      case (state_ff)
         tcgr_pkg::ST_CHECK: begin
            div_start = proceed;
            if (at_end && proceed) begin
               rsp_load    = 1'b1;
               rsp_kind_in = tcgr_pkg::KIND_CLEAR;
               rsp_last_in = op_in inside {tcgr_pkg::OP_NEWLINE, tcgr_pkg::OP_RETURN};
            end
         end
         tcgr_pkg::ST_DRAW: begin
            rsp_load    = rd_pend_ff && out_free;
            rsp_kind_in = tcgr_pkg::KIND_ROW;
            rsp_x_in    = x_ff;
            rsp_y_in    = tcgr_pkg::COORD_W'(y0_ff + tcgr_pkg::COORD_W'(emi_cnt_ff));
            rsp_bits_in = rd_data_ff;
            rsp_last_in = draw_last;
            rd_en       = (iss_cnt_ff != RW'(GLYPH_ROWS)) && (!rd_pend_ff || rsp_load);
         end
         default: ;
      endcase
   end

   // sequencer control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tcgr_pkg::ST_IDLE;
         cursor_ff  <= '0;
         rd_pend_ff <= 1'b0;
         iss_cnt_ff <= '0;
         emi_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == tcgr_pkg::ST_DIV) && div_res.done) begin
            cursor_ff  <= cursor_in;
            iss_cnt_ff <= '0;
            emi_cnt_ff <= '0;
            rd_pend_ff <= 1'b0;
         end else if (state_ff == tcgr_pkg::ST_DRAW) begin
            if (rd_en) begin
               iss_cnt_ff <= RW'(iss_cnt_ff + RW'(1));
               rd_pend_ff <= 1'b1;
            end else if (rsp_load) begin
               rd_pend_ff <= 1'b0;
            end
            if (rsp_load) emi_cnt_ff <= RW'(emi_cnt_ff + RW'(1));
         end
      end
   end

   // per-character working values
   always_ff @(posedge clock) begin
      if (req_acc) char_ff <= req_char_code;
      if ((state_ff == tcgr_pkg::ST_CHECK) && proceed) begin
         op_ff      <= op_in;
         pos_cur_ff <= pos_cur;
         base_ff    <= base_in;
      end
      if ((state_ff == tcgr_pkg::ST_DIV) && div_res.done) begin
         x_ff  <= div_res.rem[tcgr_pkg::COORD_W-1:0];
         y0_ff <= tcgr_pkg::COORD_W'(div_res.quot[tcgr_pkg::COORD_W-1:0]
                  * tcgr_pkg::COORD_W'(GLYPH_ROWS));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_bits_ff <= rsp_bits_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_pixel_x  = rsp_x_ff;
   assign rsp_pixel_y  = rsp_y_ff;
   assign rsp_row_bits = rsp_bits_ff;
   assign rsp_last     = rsp_last_ff;

   // checks
   assign rd_ahead_ok   = (iss_cnt_ff == emi_cnt_ff)
                          || (iss_cnt_ff == RW'(emi_cnt_ff + RW'(1)));
   assign last_row_done = (state_ff == tcgr_pkg::ST_DRAW) && rsp_load && draw_last;

   `TCGR_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !rsp_load)
   `TCGR_ASSERT_IMPLY(a_div_done_in_div, clock, reset, div_res.done, state_ff == tcgr_pkg::ST_DIV)
   `TCGR_ASSERT_IMPLY(a_read_ahead_one, clock, reset, state_ff == tcgr_pkg::ST_DRAW, rd_ahead_ok)
   `TCGR_ASSERT_NEXT(a_last_row_ends, clock, reset, last_row_done, state_ff == tcgr_pkg::ST_IDLE)

endmodule

`default_nettype wire
